>>> rtl/assert_macros.svh
// Assertion helpers for the RTL. Synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

>>> rtl/gtg_pkg.sv
`default_nettype none

package gtg_pkg;

	// Default datapath sizes
	localparam int unsigned RATE_BITS_DEF  = 16;
	localparam int unsigned ANGLE_BITS_DEF = 40;

	// Register file geometry: 64-bit words at byte address 8*index
	localparam int unsigned APB_ADDR_W  = 6;
	localparam int unsigned APB_DATA_W  = 64;
	localparam int unsigned REG_IDX_LSB = 3;
	localparam int unsigned REG_IDX_W   = 3;
	localparam int unsigned THR_W       = 40;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_AXIS_SELECT     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_RATE_GATE       = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAP_TIMEOUT     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ANGLE_THRESHOLD = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MAX_DURATION    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DOMINANCE_RATIO = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_REFRACTORY      = 3'd6;

	// Axis codes; any other code selects z
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;

	// Reset values
	localparam logic [1:0]       AXIS_SELECT_RST     = 2'd2;
	localparam logic [15:0]      RATE_GATE_RST       = 16'd960;
	localparam logic [15:0]      GAP_TIMEOUT_RST     = 16'd150;
	localparam logic [THR_W-1:0] ANGLE_THRESHOLD_RST = 40'd1440000;
	localparam logic [15:0]      MAX_DURATION_RST    = 16'd800;
	localparam logic [7:0]       DOMINANCE_RATIO_RST = 8'd32;
	localparam logic [15:0]      REFRACTORY_RST      = 16'd500;

	typedef struct packed {
		logic [1:0]       axis_select;
		logic [15:0]      rate_gate;
		logic [15:0]      gap_timeout_ms;
		logic [THR_W-1:0] angle_threshold;
		logic [15:0]      max_duration_ms;
		logic [7:0]       dominance_ratio;
		logic [15:0]      refractory_ms;
	} gtg_cfg_t;

endpackage

`default_nettype wire

>>> rtl/gtg_regs.sv
`default_nettype none

module gtg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [gtg_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [gtg_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [gtg_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output gtg_pkg::gtg_cfg_t                cfg
);
	import gtg_pkg::*;

	gtg_cfg_t             cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[REG_IDX_LSB +: REG_IDX_W];
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// Register writes; unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis_select     <= AXIS_SELECT_RST;
			cfg_q.rate_gate       <= RATE_GATE_RST;
			cfg_q.gap_timeout_ms  <= GAP_TIMEOUT_RST;
			cfg_q.angle_threshold <= ANGLE_THRESHOLD_RST;
			cfg_q.max_duration_ms <= MAX_DURATION_RST;
			cfg_q.dominance_ratio <= DOMINANCE_RATIO_RST;
			cfg_q.refractory_ms   <= REFRACTORY_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_AXIS_SELECT:     cfg_q.axis_select     <= pwdata[1:0];
				REG_RATE_GATE:       cfg_q.rate_gate       <= pwdata[15:0];
				REG_GAP_TIMEOUT:     cfg_q.gap_timeout_ms  <= pwdata[15:0];
				REG_ANGLE_THRESHOLD: cfg_q.angle_threshold <= pwdata[THR_W-1:0];
				REG_MAX_DURATION:    cfg_q.max_duration_ms <= pwdata[15:0];
				REG_DOMINANCE_RATIO: cfg_q.dominance_ratio <= pwdata[7:0];
				REG_REFRACTORY:      cfg_q.refractory_ms   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_AXIS_SELECT:     prdata = APB_DATA_W'(cfg_q.axis_select);
			REG_RATE_GATE:       prdata = APB_DATA_W'(cfg_q.rate_gate);
			REG_GAP_TIMEOUT:     prdata = APB_DATA_W'(cfg_q.gap_timeout_ms);
			REG_ANGLE_THRESHOLD: prdata = APB_DATA_W'(cfg_q.angle_threshold);
			REG_MAX_DURATION:    prdata = APB_DATA_W'(cfg_q.max_duration_ms);
			REG_DOMINANCE_RATIO: prdata = APB_DATA_W'(cfg_q.dominance_ratio);
			REG_REFRACTORY:      prdata = APB_DATA_W'(cfg_q.refractory_ms);
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/gyro_twist_gesture_detector_unit.sv
// Twist gesture detector: takes one gyro word (three signed rates plus a
// millisecond timestamp) per cycle and returns one result word (fired,
// tracking) per sample, in order. Sustained rate is one sample per clock
// unless the result side stalls. Samples pass the stage-1, stage-2 and
// result registers (stage 1 forms the rate magnitudes, sample interval and
// the rate-times-interval product; stage 2 runs the gesture state update -
// 40-bit angle add with saturation, threshold compare and the 8x16 dominance
// multiply). That stage-2 state loop is the timing path that bounds the
// clock. Configuration sits behind a 64-bit APB port, register i at byte
// address 8*i, and may be written only while no sample is in flight. No
// memory, no clearing pass: the block is ready right out of reset.
`default_nettype none

module gyro_twist_gesture_detector_unit #(
	parameter int unsigned RATE_BITS  = gtg_pkg::RATE_BITS_DEF,
	parameter int unsigned ANGLE_BITS = gtg_pkg::ANGLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gtg_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [gtg_pkg::APB_DATA_W-1:0] pwdata,
	output logic [gtg_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	// sample channel
	input  logic                           sample_valid,
	output logic                           sample_ready,
	input  logic signed [RATE_BITS-1:0]    rate_x,
	input  logic signed [RATE_BITS-1:0]    rate_y,
	input  logic signed [RATE_BITS-1:0]    rate_z,
	input  logic [31:0]                    time_ms,
	// result channel
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic                           fired,
	output logic                           tracking
);
	import gtg_pkg::*;

	`include "assert_macros.svh"

	localparam int unsigned GATE_W = (RATE_BITS > 16) ? RATE_BITS : 16;
	localparam int unsigned PROD_W = RATE_BITS + 16;
	localparam int unsigned SUM_W  = ((ANGLE_BITS > PROD_W) ? ANGLE_BITS : PROD_W) + 1;
	localparam int unsigned CMP_W  = (ANGLE_BITS > THR_W) ? ANGLE_BITS : THR_W;
	localparam int unsigned DOM_W  = RATE_BITS + 8;

	gtg_cfg_t cfg;

	gtg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---------------- flow control ----------------
	logic s1_v, s2_v, result_valid_q;
	logic rdy_out, rdy_s2, rdy_s1, go_s1, go_s2, take;

	assign rdy_out      = !result_valid_q || result_ready;
	assign rdy_s2       = !s2_v || rdy_out;
	assign go_s2        = s2_v && rdy_out;
	assign rdy_s1       = !s1_v || rdy_s2;
	assign go_s1        = s1_v && rdy_s2;
	assign sample_ready = rdy_s1;
	assign take         = sample_valid && rdy_s1;
	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v           <= 1'b0;
			s2_v           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  s1_v           <= take;
			if (rdy_s2)  s2_v           <= go_s1;
			if (rdy_out) result_valid_q <= go_s2;
		end
	end

	// ---------------- stage 1: input register ----------------
	logic signed [RATE_BITS-1:0] rate_x_s1, rate_y_s1, rate_z_s1;
	logic [31:0]                 time_s1;

	always_ff @(posedge clk) begin
		if (take) begin
			rate_x_s1 <= rate_x;
			rate_y_s1 <= rate_y;
			rate_z_s1 <= rate_z;
			time_s1   <= time_ms;
		end
	end

	// timestamp of the previous sample, whatever branch it took
	logic [31:0] prev_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q <= '0;
		end else if (go_s1) begin
			prev_time_q <= time_s1;
		end
	end

	// magnitudes; full-scale negative maps to 2^(RATE_BITS-1) exactly
	logic [RATE_BITS-1:0] mag_x, mag_y, mag_z;
	logic [RATE_BITS-1:0] main_mag, o1_mag, o2_mag, other_mag;
	logic                 main_neg, below_gate;
	logic [31:0]          dt_raw;
	logic [15:0]          dt_sat;
	logic [PROD_W-1:0]    prod;

	assign mag_x = rate_x_s1[RATE_BITS-1] ? RATE_BITS'(-rate_x_s1) : RATE_BITS'(rate_x_s1);
	assign mag_y = rate_y_s1[RATE_BITS-1] ? RATE_BITS'(-rate_y_s1) : RATE_BITS'(rate_y_s1);
	assign mag_z = rate_z_s1[RATE_BITS-1] ? RATE_BITS'(-rate_z_s1) : RATE_BITS'(rate_z_s1);

	// main axis select
	always_comb begin
		unique case (cfg.axis_select)
			AXIS_X: begin
				main_mag = mag_x;
				main_neg = rate_x_s1[RATE_BITS-1];
				o1_mag   = mag_y;
				o2_mag   = mag_z;
			end
			AXIS_Y: begin
				main_mag = mag_y;
				main_neg = rate_y_s1[RATE_BITS-1];
				o1_mag   = mag_z;
				o2_mag   = mag_x;
			end
			default: begin
				main_mag = mag_z;
				main_neg = rate_z_s1[RATE_BITS-1];
				o1_mag   = mag_x;
				o2_mag   = mag_y;
			end
		endcase
	end

	assign other_mag  = (o1_mag > o2_mag) ? o1_mag : o2_mag;
	assign below_gate = GATE_W'(main_mag) < GATE_W'(cfg.rate_gate);
	assign dt_raw     = time_s1 - prev_time_q;
	assign dt_sat     = (dt_raw[31:16] != '0) ? 16'hFFFF : dt_raw[15:0];
	assign prod       = PROD_W'(main_mag) * PROD_W'(dt_sat);

	// ---------------- stage 2 register ----------------
	logic [RATE_BITS-1:0] mag_s2, other_s2;
	logic                 neg_s2, below_s2;
	logic [PROD_W-1:0]    prod_s2;
	logic [31:0]          time_s2;

	always_ff @(posedge clk) begin
		if (go_s1) begin
			mag_s2   <= main_mag;
			other_s2 <= other_mag;
			neg_s2   <= main_neg;
			below_s2 <= below_gate;
			prod_s2  <= prod;
			time_s2  <= time_s1;
		end
	end

	// ---------------- gesture state ----------------
	logic                  active_q, dir_q, ever_q;
	logic [ANGLE_BITS-1:0] angle_sum_q;
	logic [RATE_BITS-1:0]  peak_main_q, peak_cross_q;
	logic [31:0]           start_q, last_above_q, last_acc_q;

	logic                  nxt_active, nxt_dir, nxt_ever;
	logic [ANGLE_BITS-1:0] nxt_sum;
	logic [RATE_BITS-1:0]  nxt_pm, nxt_pc;
	logic [31:0]           nxt_start, nxt_last_above, nxt_last_acc;
	logic                  res_fired, res_tracking;

	// a new gesture starts on first above-gate sample or on a sign change
	logic                  restart, gap_drop, done, accept;
	logic [ANGLE_BITS-1:0] sum_base, sum_new;
	logic [PROD_W-1:0]     add_term;
	logic [SUM_W-1:0]      sum_ext;
	logic [RATE_BITS-1:0]  pm_base, pc_base, pm_new, pc_new;
	logic [31:0]           start_base;
	logic [DOM_W-1:0]      dom_lhs, dom_rhs;
	logic                  dur_ok, dom_ok, refr_ok;

	assign restart    = !active_q || (neg_s2 != dir_q);
	assign gap_drop   = active_q && ((time_s2 - last_above_q) > 32'(cfg.gap_timeout_ms));
	assign sum_base   = restart ? '0 : angle_sum_q;
	assign add_term   = restart ? '0 : prod_s2;
	assign pm_base    = restart ? '0 : peak_main_q;
	assign pc_base    = restart ? '0 : peak_cross_q;
	assign start_base = restart ? time_s2 : start_q;

	// saturating angle accumulate
	assign sum_ext = SUM_W'(sum_base) + SUM_W'(add_term);
	assign sum_new = (sum_ext[SUM_W-1:ANGLE_BITS] != '0) ? '1 : sum_ext[ANGLE_BITS-1:0];
	assign done    = CMP_W'(sum_new) >= CMP_W'(cfg.angle_threshold);

	assign pm_new = (mag_s2 > pm_base) ? mag_s2 : pm_base;
	assign pc_new = (other_s2 > pc_base) ? other_s2 : pc_base;

	// acceptance checks: duration, Q4.4 dominance, refractory
	assign dom_lhs = DOM_W'({pm_new, 4'b0000});
	assign dom_rhs = DOM_W'(cfg.dominance_ratio) * DOM_W'(pc_new);
	assign dur_ok  = (time_s2 - start_base) <= 32'(cfg.max_duration_ms);
	assign dom_ok  = dom_lhs >= dom_rhs;
	assign refr_ok = !ever_q || ((time_s2 - last_acc_q) >= 32'(cfg.refractory_ms));
	assign accept  = dur_ok && dom_ok && refr_ok;

	always_comb begin
		nxt_active     = active_q;
		nxt_dir        = dir_q;
		nxt_sum        = angle_sum_q;
		nxt_pm         = peak_main_q;
		nxt_pc         = peak_cross_q;
		nxt_start      = start_q;
		nxt_last_above = last_above_q;
		nxt_last_acc   = last_acc_q;
		nxt_ever       = ever_q;
		res_fired      = 1'b0;
		res_tracking   = 1'b0;
		if (below_s2) begin
			// dip below gate: keep, or drop after the gap timeout
			if (gap_drop) begin
				nxt_active     = 1'b0;
				nxt_dir        = 1'b0;
				nxt_sum        = '0;
				nxt_pm         = '0;
				nxt_pc         = '0;
				nxt_start      = '0;
				nxt_last_above = '0;
			end
			res_tracking = active_q && !gap_drop;
		end else if (!done) begin
			nxt_active     = 1'b1;
			nxt_dir        = neg_s2;
			nxt_sum        = sum_new;
			nxt_pm         = pm_new;
			nxt_pc         = pc_new;
			nxt_start      = start_base;
			nxt_last_above = time_s2;
			res_tracking   = 1'b1;
		end else begin
			// threshold reached: gesture ends either way
			nxt_active     = 1'b0;
			nxt_dir        = 1'b0;
			nxt_sum        = '0;
			nxt_pm         = '0;
			nxt_pc         = '0;
			nxt_start      = '0;
			nxt_last_above = '0;
			if (accept) begin
				nxt_last_acc = time_s2;
				nxt_ever     = 1'b1;
			end
			res_fired = accept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			dir_q        <= 1'b0;
			angle_sum_q  <= '0;
			peak_main_q  <= '0;
			peak_cross_q <= '0;
			start_q      <= '0;
			last_above_q <= '0;
			last_acc_q   <= '0;
			ever_q       <= 1'b0;
		end else if (go_s2) begin
			active_q     <= nxt_active;
			dir_q        <= nxt_dir;
			angle_sum_q  <= nxt_sum;
			peak_main_q  <= nxt_pm;
			peak_cross_q <= nxt_pc;
			start_q      <= nxt_start;
			last_above_q <= nxt_last_above;
			last_acc_q   <= nxt_last_acc;
			ever_q       <= nxt_ever;
		end
	end

	// ---------------- result register ----------------
	logic fired_q, tracking_q;

	always_ff @(posedge clk) begin
		if (go_s2) begin
			fired_q    <= res_fired;
			tracking_q <= res_tracking;
		end
	end

	assign fired    = fired_q;
	assign tracking = tracking_q;

	// ---------------- assertions ----------------
	`ASSERT_NEVER(a_fire_and_track, clk, arst_n, result_valid_q && fired_q && tracking_q, "fired and tracking together")
	`ASSERT_ALWAYS(a_idle_sum_zero, clk, arst_n, !active_q |-> (angle_sum_q == '0), "angle kept with no gesture")
	`ASSERT_ALWAYS(a_idle_peaks_zero, clk, arst_n, !active_q |-> ((peak_main_q == '0) && (peak_cross_q == '0)), "peaks kept with no gesture")
	`ASSERT_ALWAYS(a_fire_marks_ever, clk, arst_n, (result_valid_q && fired_q) |-> ever_q, "fired word without acceptance record")
	`ASSERT_ALWAYS(a_ready_when_drained, clk, arst_n, !result_valid_q |-> sample_ready, "stalled with empty result register")

endmodule

`default_nettype wire

>>> tb/twist_result_checker.sv
`timescale 1ns / 100ps

// Watches the config port and both word channels of the twist detector,
// predicts every result word and compares it against what comes out.
module twist_result_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic                                  pready,
	input  logic [gtg_pkg::APB_ADDR_W-1:0]        paddr,
	input  logic [gtg_pkg::APB_DATA_W-1:0]        pwdata,
	input  logic                                  sample_valid,
	input  logic                                  sample_ready,
	input  logic signed [gtg_pkg::RATE_BITS_DEF-1:0] rate_x,
	input  logic signed [gtg_pkg::RATE_BITS_DEF-1:0] rate_y,
	input  logic signed [gtg_pkg::RATE_BITS_DEF-1:0] rate_z,
	input  logic [31:0]                           time_ms,
	input  logic                                  result_valid,
	input  logic                                  result_ready,
	input  logic                                  fired,
	input  logic                                  tracking,
	output int                                    mismatches,
	output int                                    words_pending,
	output int                                    gestures_fired
);
	import gtg_pkg::*;

	localparam int unsigned ANGLE_W = ANGLE_BITS_DEF;
	localparam logic [ANGLE_W-1:0] ANGLE_CEIL = '1;
	localparam logic [31:0] DT_CEIL = 32'd65535;

	typedef struct packed {
		logic fired;
		logic tracking;
	} twist_word_t;

	twist_word_t expected_words[$];
	twist_word_t fresh, oldest;

	// predictor copy of config and gesture state
	gtg_cfg_t cfg;
	logic active, dir_neg, ever_fired;
	logic [ANGLE_W-1:0] angle_sum;
	int unsigned peak_main, peak_cross;
	logic [31:0] start_ms, prev_ms, above_ms, accept_ms;
	int errs, fires;

	function automatic int unsigned magn(input int v);
		return (v < 0) ? -v : v;
	endfunction

	task automatic drop_gesture();
		active = 1'b0;
		dir_neg = 1'b0;
		angle_sum = '0;
		peak_main = 0;
		peak_cross = 0;
		start_ms = '0;
		prev_ms = '0;
		above_ms = '0;
	endtask

	// one gyro word through the gesture tracker
	task automatic advance_twist(input int rx, input int ry, input int rz,
			input logic [31:0] now, output twist_word_t w);
		int r[3];
		int unsigned ax, mag, o1, o2, other;
		logic [31:0] dt;
		logic [63:0] grown;
		logic neg, ok;
		r[0] = rx;
		r[1] = ry;
		r[2] = rz;
		ax = (cfg.axis_select == AXIS_X) ? 0 : (cfg.axis_select == AXIS_Y) ? 1 : 2;
		mag = magn(r[ax]);
		o1 = magn(r[(ax + 1) % 3]);
		o2 = magn(r[(ax + 2) % 3]);
		other = (o1 > o2) ? o1 : o2;
		w = '0;
		if (mag < cfg.rate_gate) begin
			// below gate: only a long dip matters
			if (active && (now - above_ms) > 32'(cfg.gap_timeout_ms))
				drop_gesture();
			prev_ms = now;
			w.tracking = active;
		end else begin
			neg = r[ax] < 0;
			if (!active || neg != dir_neg) begin
				drop_gesture();
				active = 1'b1;
				dir_neg = neg;
				start_ms = now;
				prev_ms = now;
			end
			dt = now - prev_ms;
			if (dt > DT_CEIL)
				dt = DT_CEIL;
			prev_ms = now;
			above_ms = now;
			grown = 64'(angle_sum) + 64'(mag) * 64'(dt);
			angle_sum = (grown > 64'(ANGLE_CEIL)) ? ANGLE_CEIL : grown[ANGLE_W-1:0];
			if (mag > peak_main)
				peak_main = mag;
			if (other > peak_cross)
				peak_cross = other;
			if (angle_sum < cfg.angle_threshold) begin
				w.tracking = 1'b1;
			end else begin
				// gesture complete: duration, dominance, refractory
				ok = ((now - start_ms) <= 32'(cfg.max_duration_ms))
					&& (64'(peak_main) * 64'd16 >= 64'(cfg.dominance_ratio) * 64'(peak_cross))
					&& (!ever_fired || (now - accept_ms) >= 32'(cfg.refractory_ms));
				drop_gesture();
				if (ok) begin
					accept_ms = now;
					ever_fired = 1'b1;
				end
				w.fired = ok;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.axis_select = AXIS_SELECT_RST;
			cfg.rate_gate = RATE_GATE_RST;
			cfg.gap_timeout_ms = GAP_TIMEOUT_RST;
			cfg.angle_threshold = ANGLE_THRESHOLD_RST;
			cfg.max_duration_ms = MAX_DURATION_RST;
			cfg.dominance_ratio = DOMINANCE_RATIO_RST;
			cfg.refractory_ms = REFRACTORY_RST;
			drop_gesture();
			accept_ms = '0;
			ever_fired = 1'b0;
			expected_words.delete();
			errs = 0;
			fires = 0;
			mismatches <= 0;
			words_pending <= 0;
			gestures_fired <= 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[REG_IDX_LSB +: REG_IDX_W])
					REG_AXIS_SELECT:     cfg.axis_select = pwdata[1:0];
					REG_RATE_GATE:       cfg.rate_gate = pwdata[15:0];
					REG_GAP_TIMEOUT:     cfg.gap_timeout_ms = pwdata[15:0];
					REG_ANGLE_THRESHOLD: cfg.angle_threshold = pwdata[THR_W-1:0];
					REG_MAX_DURATION:    cfg.max_duration_ms = pwdata[15:0];
					REG_DOMINANCE_RATIO: cfg.dominance_ratio = pwdata[7:0];
					REG_REFRACTORY:      cfg.refractory_ms = pwdata[15:0];
					default: ;
				endcase
			end

			// accepted gyro word
			if (sample_valid && sample_ready) begin
				advance_twist(int'(rate_x), int'(rate_y), int'(rate_z), time_ms, fresh);
				expected_words.push_back(fresh);
			end

			// accepted result word
			if (result_valid && result_ready) begin
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected: fired %0d tracking %0d",
						fired, tracking);
					errs++;
				end else begin
					oldest = expected_words.pop_front();
					if (oldest.fired)
						fires++;
					if (fired !== oldest.fired) begin
						$error("fired: expected %0d, got %0d", oldest.fired, fired);
						errs++;
					end
					if (tracking !== oldest.tracking) begin
						$error("tracking: expected %0d, got %0d", oldest.tracking, tracking);
						errs++;
					end
				end
			end

			mismatches <= errs;
			words_pending <= expected_words.size();
			gestures_fired <= fires;
		end
	end

endmodule

>>> tb/gyro_twist_gesture_detector_unit_tb.sv
`timescale 1ns / 100ps

module gyro_twist_gesture_detector_unit_tb;
	import gtg_pkg::*;

	localparam int unsigned RB = RATE_BITS_DEF;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam logic [THR_W-1:0] LONG_THR = 40'h38_0000_0000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_WORDS = 40;
	localparam int SAT_WORDS = 125;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata, prdata;
	logic sample_valid, sample_ready;
	logic signed [RB-1:0] rate_x, rate_y, rate_z;
	logic [31:0] time_ms;
	logic result_valid, result_ready, fired, tracking;

	int mismatches, words_pending, gestures_fired;
	int words_sent;
	bit calm;
	gtg_cfg_t plan;
	logic [31:0] clock_ms;
	logic gesture_neg;

	gyro_twist_gesture_detector_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.rate_x       (rate_x),
		.rate_y       (rate_y),
		.rate_z       (rate_z),
		.time_ms      (time_ms),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.fired        (fired),
		.tracking     (tracking)
	);

	twist_result_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.rate_x         (rate_x),
		.rate_y         (rate_y),
		.rate_z         (rate_z),
		.time_ms        (time_ms),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.fired          (fired),
		.tracking       (tracking),
		.mismatches     (mismatches),
		.words_pending  (words_pending),
		.gestures_fired (gestures_fired)
	);

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// hard stop
	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// APB write: setup then access
	task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(idx) << REG_IDX_LSB;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_plan();
		put_reg(REG_AXIS_SELECT, 64'(plan.axis_select));
		put_reg(REG_RATE_GATE, 64'(plan.rate_gate));
		put_reg(REG_GAP_TIMEOUT, 64'(plan.gap_timeout_ms));
		put_reg(REG_ANGLE_THRESHOLD, 64'(plan.angle_threshold));
		put_reg(REG_MAX_DURATION, 64'(plan.max_duration_ms));
		put_reg(REG_DOMINANCE_RATIO, 64'(plan.dominance_ratio));
		put_reg(REG_REFRACTORY, 64'(plan.refractory_ms));
	endtask

	// hold the sender until every expected word is back
	task automatic settle();
		sample_valid <= 1'b0;
		do @(posedge clk); while (words_pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// one gyro word, with a random gap ahead of it
	task automatic send_word(input int x, input int y, input int z, input logic [31:0] t);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		rate_x <= RB'(x);
		rate_y <= RB'(y);
		rate_z <= RB'(z);
		time_ms <= t;
		do @(posedge clk); while (!sample_ready);
		words_sent++;
	endtask

	// result side: random stall per word
	initial begin
		int stall;
		result_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	// stimulus
	initial begin
		int ax, mag, kind, k, n, i, c, cross_lim;
		int lane[3];
		logic [31:0] stride;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sample_valid <= 1'b0;
		rate_x <= '0;
		rate_y <= '0;
		rate_z <= '0;
		time_ms <= '0;
		arst_n <= 1'b0;
		calm = 1'b0;
		words_sent = 0;
		gesture_neg = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset config (z main)
		send_word(0, 0, 0, 32'd0);
		send_word(0, 0, 32767, 32'd10);
		// reversal at full-scale negative
		send_word(0, 0, -32768, 32'd20);
		// long interval saturates, gesture too slow
		send_word(0, 0, -32768, 32'd100000);
		send_word(0, 0, 20000, 32'd200000);
		send_word(0, 0, 20000, 32'd200050);
		// first accepted gesture
		send_word(0, 0, 20000, 32'd200080);
		send_word(0, 0, 32767, 32'd200100);
		// completes inside refractory window
		send_word(0, 0, 32767, 32'd200150);
		send_word(20000, 0, 30000, 32'd201000);
		// cross axis too strong
		send_word(0, -20000, 30000, 32'd201060);
		send_word(0, 0, 10000, 32'd202000);
		// short dip keeps it, long dip drops it
		send_word(0, 0, 0, 32'd202100);
		send_word(0, 0, 0, 32'd202300);
		// timestamp wrap
		send_word(0, 0, -20000, 32'hFFFF_FFF0);
		send_word(0, 0, -20000, 32'h0000_0040);
		send_word(-32768, 32767, -1, 32'h8000_0000);
		send_word(32767, -32768, 959, 32'h8000_0010);
		send_word(0, 0, 960, 32'h8000_0020);
		settle();

		// axis code three acts as z; unmapped register ignored
		put_reg(REG_AXIS_SELECT, 64'd3);
		put_reg(REG_SPARE, '1);
		send_word(32767, 32767, 25000, 32'h8000_1000);
		send_word(32767, 32767, 25000, 32'h8000_1040);
		send_word(100, -100, -25000, 32'h8000_1080);
		send_word(100, -100, -25000, 32'h8000_10C0);

		// random phases, extremes of the config in the first four
		for (k = 0; k < RANDOM_PHASES; k++) begin
			settle();
			plan.axis_select = 2'($urandom_range(0, 3));
			plan.rate_gate = 16'($urandom_range(200, 3000));
			plan.gap_timeout_ms = 16'($urandom_range(20, 300));
			plan.angle_threshold = THR_W'($urandom_range(20000, 600000));
			plan.max_duration_ms = 16'($urandom_range(100, 1000));
			plan.dominance_ratio = 8'($urandom_range(0, 64));
			plan.refractory_ms = 16'($urandom_range(0, 400));
			case (k)
				0: begin
					plan.rate_gate = 16'd0;
					plan.angle_threshold = '0;
				end
				1: begin
					plan.rate_gate = 16'h8000;
					plan.gap_timeout_ms = 16'd0;
				end
				2: begin
					plan.gap_timeout_ms = 16'hFFFF;
					plan.max_duration_ms = 16'hFFFF;
					plan.dominance_ratio = 8'hFF;
					plan.refractory_ms = 16'hFFFF;
				end
				3: begin
					plan.max_duration_ms = 16'd0;
					plan.dominance_ratio = 8'd0;
					plan.refractory_ms = 16'd0;
				end
				default: ;
			endcase
			load_plan();
			ax = (plan.axis_select == AXIS_X) ? 0 : (plan.axis_select == AXIS_Y) ? 1 : 2;
			clock_ms = $urandom;
			for (n = 0; n < PHASE_WORDS; n++) begin
				calm = (n % 40) >= 30;
				kind = $urandom_range(0, 99);
				if (kind < 3)
					settle();
				stride = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 70000)
					: $urandom_range(1, 40);
				if ($urandom_range(0, 99) == 0)
					stride = $urandom;
				clock_ms += stride;
				if (kind < 75) begin
					// gesture word: main axis above gate, sign mostly steady
					if ($urandom_range(0, 19) == 0)
						gesture_neg = !gesture_neg;
					mag = int'(plan.rate_gate) + $urandom_range(0, 4000);
					if (mag >= 32768) begin
						mag = 32768;
						gesture_neg = 1'b1;
					end
					lane[ax] = gesture_neg ? -mag : mag;
					cross_lim = mag / 3;
					for (i = 1; i < 3; i++) begin
						if ($urandom_range(0, 6) == 0) begin
							c = int'($urandom);
						end else begin
							c = $urandom_range(0, cross_lim);
							if ($urandom_range(0, 1))
								c = -c;
						end
						lane[(ax + i) % 3] = c;
					end
				end else if (kind < 88) begin
					// dip below gate
					mag = (plan.rate_gate == 16'd0) ? 0 : $urandom_range(0, plan.rate_gate - 1);
					lane[ax] = $urandom_range(0, 1) ? -mag : mag;
					lane[(ax + 1) % 3] = $urandom_range(0, 2000);
					lane[(ax + 2) % 3] = -int'($urandom_range(0, 2000));
				end else begin
					// noise
					for (i = 0; i < 3; i++)
						lane[i] = int'($urandom);
				end
				send_word(lane[0], lane[1], lane[2], clock_ms);
			end
		end

		// one long x-axis twist, every interval saturated, threshold past 32 bits
		settle();
		calm = 1'b0;
		plan.axis_select = AXIS_X;
		plan.rate_gate = 16'd1000;
		plan.gap_timeout_ms = 16'hFFFF;
		plan.angle_threshold = LONG_THR;
		plan.max_duration_ms = 16'hFFFF;
		plan.dominance_ratio = 8'd0;
		plan.refractory_ms = 16'd0;
		load_plan();
		clock_ms = $urandom_range(0, 1000);
		for (n = 0; n < SAT_WORDS; n++) begin
			calm = (n % 40) >= 30;
			clock_ms += 32'd65535 + $urandom_range(0, 1000);
			send_word(-int'($urandom_range(32000, 32768)), $urandom_range(0, 3000),
				-int'($urandom_range(0, 3000)), clock_ms);
		end

		// drain and verdict
		settle();
		repeat (10) @(posedge clk);
		$display("run: %0d gyro words over %0d config setups, %0d gestures accepted",
			words_sent, RANDOM_PHASES + 3, gestures_fired);
		$display("run: wrap, interval saturation, refractory, dominance, gap and axis extremes");
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/gtg_pkg.sv
rtl/gtg_regs.sv
rtl/gyro_twist_gesture_detector_unit.sv
tb/twist_result_checker.sv
tb/gyro_twist_gesture_detector_unit_tb.sv
